/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RHBF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhbf assertion failed");

// next-cycle implication
`define RHBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhbf assertion failed");

`endif

/* hdl/rhbf_pkg.sv */
// types and constants of the ring histogram filter
`timescale 1ns / 1ps
package rhbf_pkg;
   localparam int PFB        = 16;
   localparam int PROB_W     = 17;
   localparam int UN_W       = 34;
   localparam int MASK_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [PROB_W-1:0] ONE = 17'h10000;

   localparam logic [CSR_IDX_W-1:0] REG_DOOR_MASK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_P_ONE_STEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_P_TWO_STEP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_P_SEEN_DOOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_P_SEEN_WALL = 3'd4;

   typedef struct packed {
      logic [MASK_W-1:0] door_mask;
      logic [PROB_W-1:0] p1;
      logic [PROB_W-1:0] p2;
      logic [PROB_W-1:0] l_door;
      logic [PROB_W-1:0] l_wall;
   } cfg_type;

   typedef struct packed {
      logic init;
      logic latch;
      logic mul;
      logic acc;
      logic div_load;
      logic div_step;
      logic div_store;
      logic rotate;
   } cmd_type;

   typedef struct packed {
      logic sum_zero;
   } sts_type;

   function automatic logic [PROB_W-1:0] sat(input logic [PROB_W-1:0] p);
      return (p > ONE) ? ONE : p;
   endfunction
endpackage

/* hdl/rhbf_if.sv */
// channel interfaces of the ring histogram filter
`timescale 1ns / 1ps
interface rhbf_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic motion;
   logic observation;
   modport source (output valid, req_type, motion, observation, input ready);
   modport sink (input valid, req_type, motion, observation, output ready);
endinterface

interface rhbf_rsp_if #(parameter int NUM_CELLS = 20);
   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  cell_index;
   logic [16:0]       probability;
   logic              last_cell;
   logic              sum_was_zero;
   modport source (output valid, cell_index, probability, last_cell, sum_was_zero,
                   input ready);
   modport sink (input valid, cell_index, probability, last_cell, sum_was_zero,
                 output ready);
endinterface

interface rhbf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [19:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rhbf_csr.sv */
// configuration registers with saturated probability outputs
`timescale 1ns / 1ps
module rhbf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [rhbf_pkg::CSR_IDX_W-1:0]      wr_idx,
   input  logic [rhbf_pkg::CSR_DATA_W-1:0]     wr_data,
   output rhbf_pkg::cfg_type                   cfg
);
   logic [rhbf_pkg::MASK_W-1:0] mask_ff;
   logic [rhbf_pkg::PROB_W-1:0] p1_ff, p2_ff, ld_ff, lw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 20'd148;
         p1_ff   <= 17'd45875;
         p2_ff   <= 17'd19661;
         ld_ff   <= 17'd52429;
         lw_ff   <= 17'd6554;
      end else if (wr_en) begin
         unique case (wr_idx)
            rhbf_pkg::REG_DOOR_MASK:   mask_ff <= wr_data;
            rhbf_pkg::REG_P_ONE_STEP:  p1_ff   <= wr_data[16:0];
            rhbf_pkg::REG_P_TWO_STEP:  p2_ff   <= wr_data[16:0];
            rhbf_pkg::REG_P_SEEN_DOOR: ld_ff   <= wr_data[16:0];
            rhbf_pkg::REG_P_SEEN_WALL: lw_ff   <= wr_data[16:0];
            default: ;
         endcase
      end
   end

   assign cfg.door_mask = mask_ff;
   assign cfg.p1        = rhbf_pkg::sat(p1_ff);
   assign cfg.p2        = rhbf_pkg::sat(p2_ff);
   assign cfg.l_door    = rhbf_pkg::sat(ld_ff);
   assign cfg.l_wall    = rhbf_pkg::sat(lw_ff);
endmodule

/* hdl/rhbf_dp.sv */
// belief ring, weighting multipliers, sum and restoring divider
`timescale 1ns / 1ps
module rhbf_dp #(
   parameter int NUM_CELLS = 20
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rhbf_pkg::cmd_type               cmd,
   input  rhbf_pkg::cfg_type               cfg,
   input  logic                            in_motion,
   input  logic                            in_obs,
   input  logic [((NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1)-1:0] cell_idx,
   output rhbf_pkg::sts_type               sts,
   output logic [rhbf_pkg::PROB_W-1:0]     head
);
   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int SUM_W = rhbf_pkg::UN_W + IDX_W;
   localparam int ONE_I = 1 << rhbf_pkg::PFB;
   localparam logic [rhbf_pkg::PROB_W-1:0] UNIFORM =
      rhbf_pkg::PROB_W'((ONE_I + NUM_CELLS / 2) / NUM_CELLS);

   logic [rhbf_pkg::PROB_W-1:0] ring_ff [NUM_CELLS];
   logic [rhbf_pkg::UN_W-1:0]   un_ff   [NUM_CELLS];
   logic [34:0]                 m_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [SUM_W:0]              rem_ff, rem_in, rem_sh;
   logic [rhbf_pkg::PROB_W-1:0] q_ff, q_in;
   logic                        motion_ff, obs_ff;
   logic [17:0]                 pred;
   logic [rhbf_pkg::PROB_W-1:0] lik_sel, lik;
   logic [34:0]                 prod;
   logic [5:0]                  cell6;
   logic                        door;

   assign cell6   = 6'(cell_idx);
   assign door    = (cell6 < 6'(rhbf_pkg::MASK_W)) && cfg.door_mask[cell6[4:0]];
   assign lik_sel = door ? cfg.l_door : cfg.l_wall;
   assign lik     = obs_ff ? lik_sel : (rhbf_pkg::ONE - lik_sel);
   assign pred    = motion_ff ? m_ff[rhbf_pkg::PFB+17:rhbf_pkg::PFB] : 18'(ring_ff[0]);
   assign prod    = pred * lik;

   always_comb begin
      rem_sh = {rem_ff[SUM_W-1:0], 1'b0};
      rem_in = rem_ff;
      q_in   = q_ff;
      if (cmd.div_load) begin
         if ((SUM_W+1)'(un_ff[0]) >= (SUM_W+1)'(sum_ff)) begin
            rem_in = (SUM_W+1)'(un_ff[0]) - (SUM_W+1)'(sum_ff);
            q_in   = rhbf_pkg::PROB_W'(1);
         end else begin
            rem_in = (SUM_W+1)'(un_ff[0]);
            q_in   = '0;
         end
      end else if (cmd.div_step) begin
         if (rem_sh >= (SUM_W+1)'(sum_ff)) begin
            rem_in = rem_sh - (SUM_W+1)'(sum_ff);
            q_in   = {q_ff[rhbf_pkg::PROB_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[rhbf_pkg::PROB_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CELLS; i++) ring_ff[i] <= UNIFORM;
      end else if (cmd.init) begin
         for (int i = 0; i < NUM_CELLS; i++) ring_ff[i] <= UNIFORM;
      end else if (cmd.acc || cmd.rotate) begin
         for (int i = 0; i < NUM_CELLS - 1; i++) ring_ff[i] <= ring_ff[i+1];
         ring_ff[NUM_CELLS-1] <= ring_ff[0];
      end else if (cmd.div_store) begin
         for (int i = 0; i < NUM_CELLS - 1; i++) ring_ff[i] <= ring_ff[i+1];
         ring_ff[NUM_CELLS-1] <= q_ff;
      end
   end

   // unnormalised line and arithmetic registers need no reset
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         motion_ff <= in_motion;
         obs_ff    <= in_obs;
         sum_ff    <= '0;
      end
      if (cmd.mul) begin
         m_ff <= 35'(cfg.p1 * ring_ff[NUM_CELLS-1]) + 35'(cfg.p2 * ring_ff[NUM_CELLS-2]);
      end
      if (cmd.acc || cmd.div_store) begin
         for (int i = 0; i < NUM_CELLS - 1; i++) un_ff[i] <= un_ff[i+1];
         un_ff[NUM_CELLS-1] <= cmd.acc ? prod[rhbf_pkg::UN_W-1:0] : un_ff[0];
      end
      if (cmd.acc) sum_ff <= sum_ff + SUM_W'(prod[rhbf_pkg::UN_W-1:0]);
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign sts.sum_zero = (sum_ff == '0);
   assign head         = ring_ff[0];
endmodule

/* hdl/rhbf_ctrl.sv */
// sequencer for initialise, predict, weight, zero check, divide and emit phases
`timescale 1ns / 1ps
module rhbf_ctrl #(
   parameter int NUM_CELLS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_update,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     zero_flag,
   output logic                     last,
   output logic [((NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1)-1:0] cell_idx,
   output rhbf_pkg::cmd_type        cmd,
   input  rhbf_pkg::sts_type        sts
);
   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(NUM_CELLS - 1);
   localparam logic [4:0] LAST_BIT = 5'(rhbf_pkg::PFB - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_ACC    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_DLOAD  = 3'd4;
   localparam logic [2:0] S_DSTEP  = 3'd5;
   localparam logic [2:0] S_DSTORE = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] cell_ff, cell_in;
   logic [4:0]       bit_ff, bit_in;
   logic             zero_ff, zero_in;

   always_comb begin
      state_in  = state_ff;
      cell_in   = cell_ff;
      bit_in    = bit_ff;
      zero_in   = zero_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cell_in = '0;
               zero_in = 1'b0;
               if (req_update) begin
                  cmd.latch = 1'b1;
                  state_in  = S_MUL;
               end else begin
                  cmd.init = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (cell_ff == LAST_CELL) begin
               cell_in  = '0;
               state_in = S_CHECK;
            end else begin
               cell_in  = cell_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_CHECK: begin
            if (sts.sum_zero) begin
               zero_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_DLOAD;
            end
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            bit_in       = '0;
            state_in     = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) state_in = S_DSTORE;
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (cell_ff == LAST_CELL) begin
               cell_in  = '0;
               state_in = S_EMIT;
            end else begin
               cell_in  = cell_ff + 1'b1;
               state_in = S_DLOAD;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.rotate = 1'b1;
               if (cell_ff == LAST_CELL) begin
                  cell_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  cell_in = cell_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cell_ff  <= '0;
         bit_ff   <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cell_ff  <= cell_in;
         bit_ff   <= bit_in;
         zero_ff  <= zero_in;
      end
   end

   assign zero_flag = zero_ff;
   assign last      = (cell_ff == LAST_CELL);
   assign cell_idx  = cell_ff;
endmodule

/* hdl/ring_histogram_bayes_filter_unit.sv */
// top level of the ring histogram bayes filter
//
//  channel   role    carries
//  req_if    sink    req_type, motion, observation
//  rsp_if    source  cell_index, probability, last_cell, sum_was_zero
//  csr_if    sink    register index, write data (always ready)
//
// initialise: the uniform belief is loaded, then one result per cycle while rsp is ready
// update: predict and weight per cell (multiplier pair then weighting
//   multiplier), a zero check, then a restoring divide per cell (load,
//   quotient bit steps, store) unless the sum is zero, then NUM_CELLS transfers
// synchronous active-high reset restores uniform belief and default registers
// rsp stalls hold the emit phase; no new request is taken until the last cell
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ring_histogram_bayes_filter_unit #(
   parameter int NUM_CELLS = 20
) (
   input  logic         clock,
   input  logic         reset,
   rhbf_req_if.sink     req_if,
   rhbf_rsp_if.source   rsp_if,
   rhbf_csr_if.sink     csr_if
);
   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

   rhbf_pkg::cfg_type           cfg;
   rhbf_pkg::cmd_type           cmd;
   rhbf_pkg::sts_type           sts;
   logic [IDX_W-1:0]            cell_idx;
   logic [rhbf_pkg::PROB_W-1:0] head;
   logic                        zero_flag, last;

   // config writes always land at once
   assign csr_if.ready = 1'b1;

   rhbf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_if.valid),
      .wr_idx  (csr_if.index),
      .wr_data (csr_if.data),
      .cfg     (cfg)
   );

   rhbf_ctrl #(.NUM_CELLS(NUM_CELLS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_update (req_if.req_type),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .zero_flag  (zero_flag),
      .last       (last),
      .cell_idx   (cell_idx),
      .cmd        (cmd),
      .sts        (sts)
   );

   rhbf_dp #(.NUM_CELLS(NUM_CELLS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .in_motion (req_if.motion),
      .in_obs    (req_if.observation),
      .cell_idx  (cell_idx),
      .sts       (sts),
      .head      (head)
   );

   // results come straight off the head of the belief ring
   assign rsp_if.cell_index   = cell_idx;
   assign rsp_if.probability  = head;
   assign rsp_if.last_cell    = last;
   assign rsp_if.sum_was_zero = zero_flag;

   // one item at a time: no request while results are being shown
   `RHBF_ASSERT_NOW(a_no_overlap, clock, reset, rsp_if.valid, !req_if.ready)
   // the final cell transfer returns the block to idle
   `RHBF_ASSERT_NEXT(a_last_idle, clock, reset,
      rsp_if.valid && rsp_if.ready && rsp_if.last_cell, req_if.ready)
   // an update transfer starts work, not output
   `RHBF_ASSERT_NEXT(a_upd_busy, clock, reset,
      req_if.valid && req_if.ready && req_if.req_type, !rsp_if.valid && !req_if.ready)
   // an initialise transfer goes straight to output with a clear flag
   `RHBF_ASSERT_NEXT(a_init_emit, clock, reset,
      req_if.valid && req_if.ready && !req_if.req_type,
      rsp_if.valid && !rsp_if.sum_was_zero)
endmodule

/* sim/tb_rhbf_channels.sv */
// testbench-side channel interfaces are those of the rtl; this file holds the scoreboard class
`timescale 1ns / 1ps
package tb_rhbf_score_pkg;
   typedef struct packed {
      logic [4:0]  cell_index;
      logic [16:0] probability;
      logic        last_cell;
      logic        sum_was_zero;
   } cell_rsp_type;

   class belief_scoreboard;
      cell_rsp_type pending_cells[$];
      int unsigned mismatches;
      int unsigned cells_checked;

      function new();
         mismatches = 0;
         cells_checked = 0;
      endfunction

      function void note_request(cell_rsp_type cells[$]);
         foreach (cells[k]) pending_cells.push_back(cells[k]);
      endfunction

      function void check_cell(cell_rsp_type got);
         cell_rsp_type want;
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected cell transfer: cell %0d prob %0d", got.cell_index,
                        got.probability);
            return;
         end
         want = pending_cells.pop_front();
         cells_checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"cell mismatch: want idx %0d p %0d last %0b zero %0b, ",
                         "got idx %0d p %0d last %0b zero %0b"},
                        want.cell_index, want.probability, want.last_cell,
                        want.sum_was_zero, got.cell_index, got.probability,
                        got.last_cell, got.sum_was_zero);
         end
      endfunction
   endclass
endpackage

/* sim/tb_ring_histogram_bayes_filter_unit.sv */
// self-checking testbench of the ring histogram bayes filter
`timescale 1ns / 1ps
module tb_ring_histogram_bayes_filter_unit;
   localparam int N = 20;
   localparam longint unsigned ONE_L = 65536;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   rhbf_req_if req_if ();
   rhbf_rsp_if #(.NUM_CELLS(N)) rsp_if ();
   rhbf_csr_if csr_if ();

   ring_histogram_bayes_filter_unit #(.NUM_CELLS(N)) i_dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   tb_rhbf_score_pkg::belief_scoreboard board;

   // own copy of belief and registers
   longint unsigned model_belief[N];
   longint unsigned weighted_cell[N];
   longint unsigned mdl_door;
   longint unsigned mdl_p1, mdl_p2, mdl_ld, mdl_lw;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   bit recv_hold;
   int unsigned cycle_count;
   int unsigned requests_sent;
   int unsigned zero_sum_seen;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("ring_histogram_bayes_filter_unit regression: fail");
            $finish;
         end
      end
   end

   function automatic longint unsigned clip_one(longint unsigned p);
      return (p > ONE_L) ? ONE_L : p;
   endfunction

   function automatic longint unsigned divide_scaled(longint unsigned num,
                                                      longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      if (r >= den) begin
         q = 1;
         r -= den;
      end
      for (int i = 0; i < rhbf_pkg::PFB; i++) begin
         r <<= 1;
         q <<= 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return q;
   endfunction

   function automatic void reset_model();
      mdl_door = 148;
      mdl_p1 = 45875;
      mdl_p2 = 19661;
      mdl_ld = 52429;
      mdl_lw = 6554;
      foreach (model_belief[c]) model_belief[c] = 3277;
   endfunction

   // belief after one request, plus the cells that it emits
   function automatic void predict_request(bit upd, bit mov, bit obs);
      tb_rhbf_score_pkg::cell_rsp_type cells[$];
      tb_rhbf_score_pkg::cell_rsp_type one_cell;
      longint unsigned p1, p2, ld, lw, sum, pred, lik;
      bit zero_flag;
      p1 = clip_one(mdl_p1);
      p2 = clip_one(mdl_p2);
      ld = clip_one(mdl_ld);
      lw = clip_one(mdl_lw);
      sum = 0;
      zero_flag = 1'b0;
      if (!upd) begin
         foreach (model_belief[c]) model_belief[c] = 3277;
      end else begin
         for (int c = 0; c < N; c++) begin
            if (mov)
               pred = (p1 * model_belief[(c + N - 1) % N]
                       + p2 * model_belief[(c + N - 2) % N]) >> rhbf_pkg::PFB;
            else
               pred = model_belief[c];
            lik = mdl_door[c] ? ld : lw;
            if (!obs) lik = ONE_L - lik;
            weighted_cell[c] = pred * lik;
            sum += weighted_cell[c];
         end
         if (sum == 0) begin
            zero_flag = 1'b1;
            zero_sum_seen++;
         end else begin
            for (int c = 0; c < N; c++)
               model_belief[c] = divide_scaled(weighted_cell[c], sum);
         end
      end
      for (int c = 0; c < N; c++) begin
         one_cell.cell_index = c[4:0];
         one_cell.probability = model_belief[c][16:0];
         one_cell.last_cell = (c == N - 1);
         one_cell.sum_was_zero = zero_flag;
         cells.push_back(one_cell);
      end
      board.note_request(cells);
   endfunction

   task automatic send_request(bit upd, bit mov, bit obs);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      req_if.valid <= 1'b1;
      req_if.req_type <= upd;
      req_if.motion <= mov;
      req_if.observation <= obs;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      // transfer at this edge
      predict_request(upd, mov, obs);
      requests_sent++;
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every cell has come back, then let the divider settle
   task automatic drain_cells();
      while (board.pending_cells.size() != 0) @(posedge clock);
      repeat (N * 22) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [19:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         rhbf_pkg::REG_DOOR_MASK:   mdl_door = value;
         rhbf_pkg::REG_P_ONE_STEP:  mdl_p1 = value[16:0];
         rhbf_pkg::REG_P_TWO_STEP:  mdl_p2 = value[16:0];
         rhbf_pkg::REG_P_SEEN_DOOR: mdl_ld = value[16:0];
         rhbf_pkg::REG_P_SEEN_WALL: mdl_lw = value[16:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(longint unsigned door, longint unsigned p1,
                            longint unsigned p2, longint unsigned ld,
                            longint unsigned lw);
      write_register(rhbf_pkg::REG_DOOR_MASK, door[19:0]);
      write_register(rhbf_pkg::REG_P_ONE_STEP, p1[19:0]);
      write_register(rhbf_pkg::REG_P_TWO_STEP, p2[19:0]);
      write_register(rhbf_pkg::REG_P_SEEN_DOOR, ld[19:0]);
      write_register(rhbf_pkg::REG_P_SEEN_WALL, lw[19:0]);
   endtask

   task automatic random_batch(int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(15);
         // mostly updates, an occasional re-initialise
         send_request(pick != 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   // receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (recv_hold)
            rsp_if.ready <= 1'b0;
         else
            rsp_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // result monitor, sampled at the edge
   always @(posedge clock) begin
      tb_rhbf_score_pkg::cell_rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.cell_index = 5'(rsp_if.cell_index);
         got.probability = rsp_if.probability;
         got.last_cell = rsp_if.last_cell;
         got.sum_was_zero = rsp_if.sum_was_zero;
         board.check_cell(got);
      end
   end

   // long receiver hold-off counted in its own process
   task automatic hold_receiver(int cycles);
      recv_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      recv_hold = 1'b0;
   endtask

   initial begin
      board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      recv_hold = 1'b0;
      requests_sent = 0;
      zero_sum_seen = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = 1'b0;
      req_if.motion = 1'b0;
      req_if.observation = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset belief, every operation, ignored fields on initialise
      send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b1, 1'b1, 1'b1);
      send_request(1'b1, 1'b1, 1'b0);
      send_request(1'b1, 1'b0, 1'b1);
      send_request(1'b0, 1'b1, 1'b1);
      send_request(1'b0, 1'b0, 1'b0);
      drain_cells();
      // saturated probabilities, full mask, ignored register index
      write_all(20'hFFFFF, 20'hFFFFF, 20'h1FFFF, 20'h1FFFF, 20'h10000);
      write_register(3'd5, 20'h12345);
      write_register(3'd7, 20'hABCDE);
      send_request(1'b1, 1'b1, 1'b1);
      send_request(1'b1, 1'b0, 1'b0); // zero sum: complement of one everywhere
      send_request(1'b1, 1'b1, 1'b1);
      drain_cells();
      // zero motion probabilities: sum goes to zero on motion
      write_all(20'h00000, 0, 0, 0, 0);
      send_request(1'b1, 1'b1, 1'b0);
      send_request(1'b1, 1'b0, 1'b1); // zero likelihood everywhere
      send_request(1'b1, 1'b0, 1'b0);
      send_request(1'b0, 1'b0, 1'b1);
      drain_cells();
      // single door, sharp sensor
      write_all(20'h80000, 65536, 0, 65536, 0);
      send_request(1'b1, 1'b0, 1'b1);
      send_request(1'b1, 1'b1, 1'b1);
      send_request(1'b1, 1'b1, 1'b0);
      drain_cells();

      // long receiver hold-off while requests keep coming
      write_all(148, 45875, 19661, 52429, 6554);
      fork
         hold_receiver(3000);
         random_batch(4);
      join
      drain_cells();

      // random phases with varying registers and idling
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         write_all($urandom_range(20'hFFFFF), $urandom_range(65536 + 4),
                   $urandom_range(65536 + 4), $urandom_range(65536 + 4),
                   $urandom_range(65536 + 4));
         random_batch(48);
         drain_cells();
      end

      $display("sent %0d requests, checked %0d cell transfers, %0d zero-sum updates",
               requests_sent, board.cells_checked, zero_sum_seen);
      $display("phases covered free flow, sender idling, receiver stalls and a long hold-off");
      if (board.mismatches == 0 && board.pending_cells.size() == 0)
         $display("ring_histogram_bayes_filter_unit regression: pass");
      else
         $display("ring_histogram_bayes_filter_unit regression: fail");
      $finish;
   end
endmodule
